>>> src/assert_macros.svh
// Shared assertion macros for the encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> src/b64lw_pkg.sv
`default_nettype none

package b64lw_pkg;

  // Line width, rounded down to whole quartets
  localparam int LINE_CHARS = 64;
  localparam int LineWidth  = (LINE_CHARS / 4) * 4;
  localparam int ColW       = $clog2(LineWidth);

  // Job queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] PadChar     = 8'h3D;
  localparam logic [7:0] NewlineChar = 8'h0A;
  localparam logic [1:0] LastSym     = 2'd3;

  // Padding of a quartet: none, one '=' (two bytes), two '=' (one byte)
  typedef enum logic [1:0] {
    PAD_NONE,
    PAD_ONE,
    PAD_TWO
  } pad_e;

  typedef struct packed {
    logic [23:0] group;
    pad_e        pad;
    logic        fin;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } qwr_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } qhead_t;

  // Map a 6-bit value to its base64 symbol
  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return w + 8'd65;
    end else if (v < 6'd52) begin
      return w + 8'd71;
    end else if (v < 6'd62) begin
      return w - 8'd4;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

`default_nettype wire

>>> src/b64lw_in_if.sv
`default_nettype none

interface b64lw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

`default_nettype wire

>>> src/b64lw_out_if.sv
`default_nettype none

interface b64lw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       message_end;

  modport source (output valid, output out_char, output run_last, output message_end,
                  input ready);
  modport sink   (input valid, input out_char, input run_last, input message_end,
                  output ready);
endinterface

`default_nettype wire

>>> src/b64lw_queue.sv
`default_nettype none
`include "assert_macros.svh"

module b64lw_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64lw_pkg::qwr_t   wr_i,
  input  logic              pop_i,
  output logic              full_o,
  output b64lw_pkg::qhead_t head_o
);
  import b64lw_pkg::*;

  job_t             slot_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o       = (count_q == QCntW'(QueueDepth));
  assign head_o.valid = (count_q != '0);
  assign head_o.job   = slot_q[rd_ptr_q];

  // Store a pushed job
  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      slot_q[wr_ptr_q] <= wr_i.job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i.push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({wr_i.push, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, full_o, !wr_i.push)
  `ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop_i, head_o.valid)

endmodule

`default_nettype wire

>>> src/b64lw_front.sv
`default_nettype none
`include "assert_macros.svh"

module b64lw_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  b64lw_in_if.sink        byte_i,
  input  logic            q_full_i,
  output b64lw_pkg::qwr_t q_wr_o
);
  import b64lw_pkg::*;

  logic [15:0] held_q, held_d;
  logic [1:0]  phase_q, phase_d;
  logic        accept;

  assign byte_i.ready = !q_full_i;
  assign accept       = byte_i.valid && byte_i.ready;

  // Collect bytes into groups, hand finished groups to the queue
  always_comb begin
    held_d       = held_q;
    phase_d      = phase_q;
    q_wr_o.push  = 1'b0;
    q_wr_o.job   = '{group: {held_q, byte_i.data_byte}, pad: PAD_NONE, fin: byte_i.last};
    if (accept) begin
      if (phase_q == 2'd2) begin
        q_wr_o.push = 1'b1;
        held_d      = '0;
        phase_d     = '0;
      end else if (!byte_i.last) begin
        if (phase_q == 2'd0) begin
          held_d = {byte_i.data_byte, 8'h00};
        end else begin
          held_d = {held_q[15:8], byte_i.data_byte};
        end
        phase_d = phase_q + 2'd1;
      end else begin
        q_wr_o.push = 1'b1;
        if (phase_q == 2'd0) begin
          q_wr_o.job.group = {byte_i.data_byte, 16'h0000};
          q_wr_o.job.pad   = PAD_TWO;
        end else begin
          q_wr_o.job.group = {held_q[15:8], byte_i.data_byte, 8'h00};
          q_wr_o.job.pad   = PAD_ONE;
        end
        held_d  = '0;
        phase_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      phase_q <= '0;
    end else begin
      held_q  <= held_d;
      phase_q <= phase_d;
    end
  end

  `ASSERT_IMPL(a_phase_range, clk_i, rst_ni, 1'b1, phase_q != 2'd3)
  `ASSERT_NEXT(a_last_clears, clk_i, rst_ni, accept && byte_i.last, phase_q == 2'd0)

endmodule

`default_nettype wire

>>> src/b64lw_back.sv
`default_nettype none
`include "assert_macros.svh"

module b64lw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64lw_pkg::qhead_t head_i,
  output logic              pop_o,
  b64lw_out_if.source       char_o
);
  import b64lw_pkg::*;

  logic [7:0]      char_q, char_d;
  logic            run_last_q, run_last_d;
  logic            msg_end_q, msg_end_d;
  logic            valid_q, valid_d;
  logic [1:0]      idx_q, idx_d;
  logic            nl_q, nl_d;
  logic [ColW-1:0] col_q, col_d;
  logic            adv;
  logic            line_full;
  logic            need_nl;
  logic            is_pad;
  logic [5:0]      field;

  assign char_o.valid       = valid_q;
  assign char_o.out_char    = char_q;
  assign char_o.run_last    = run_last_q;
  assign char_o.message_end = msg_end_q;

  assign adv = !valid_q || char_o.ready;

  // Pick the 6-bit field of the current symbol
  always_comb begin
    case (idx_q)
      2'd0:    field = head_i.job.group[23:18];
      2'd1:    field = head_i.job.group[17:12];
      2'd2:    field = head_i.job.group[11:6];
      default: field = head_i.job.group[5:0];
    endcase
  end

  assign is_pad = ((head_i.job.pad == PAD_TWO) && idx_q[1])
               || ((head_i.job.pad == PAD_ONE) && (idx_q == LastSym));

  // Emit one character per cycle while the output advances and a job waits, newline after a full line or at message end
  always_comb begin
    char_d     = char_q;
    run_last_d = run_last_q;
    msg_end_d  = msg_end_q;
    valid_d    = valid_q && !char_o.ready;
    idx_d      = idx_q;
    nl_d       = nl_q;
    col_d      = col_q;
    pop_o      = 1'b0;
    line_full  = (col_q == ColW'(LineWidth - 1));
    need_nl    = line_full || head_i.job.fin;
    if (adv) begin
      if (nl_q) begin
        valid_d    = 1'b1;
        char_d     = NewlineChar;
        run_last_d = 1'b1;
        msg_end_d  = head_i.job.fin;
        nl_d       = 1'b0;
        pop_o      = 1'b1;
      end else if (head_i.valid) begin
        valid_d    = 1'b1;
        char_d     = is_pad ? PadChar : sym_char(field);
        run_last_d = 1'b0;
        msg_end_d  = 1'b0;
        idx_d      = idx_q + 2'd1;
        if (idx_q == LastSym) begin
          col_d      = need_nl ? '0 : col_q + 1'b1;
          nl_d       = need_nl;
          run_last_d = !need_nl;
          pop_o      = !need_nl;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
      nl_q    <= 1'b0;
      col_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
      nl_q    <= nl_d;
      col_q   <= col_d;
    end
  end

  // Hold the payload while the request waits
  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    run_last_q <= run_last_d;
    msg_end_q  <= msg_end_d;
  end

  `ASSERT_IMPL(a_col_tracks_idx, clk_i, rst_ni, 1'b1, col_q[1:0] == idx_q)
  `ASSERT_IMPL(a_nl_at_quartet_end, clk_i, rst_ni, nl_q, idx_q == 2'd0)

endmodule

`default_nettype wire

>>> src/base64_encoder_line_wrap.sv
// Channel   Dir  Payload                                Handshake
// byte_i    in   data_byte[7:0], last                   valid/ready
// char_o    out  out_char[7:0], run_last, message_end   valid/ready
//
// The front takes one byte per cycle while the two-entry job queue has room.
// The back sends one character per cycle while char_o is ready and a job is queued:
// 4 per 3-byte group, plus a newline after each full line and at message end.
// Each character is driven from the single output character register.
// Reset (async, active low) empties the queue and clears group and column state.
// A stalled output holds its request; the front keeps taking bytes until the queue fills.
`default_nettype none

module base64_encoder_line_wrap (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64lw_in_if.sink    byte_i,
  b64lw_out_if.source char_o
);
  import b64lw_pkg::*;

  qwr_t   q_wr;
  qhead_t q_head;
  logic   q_full;
  logic   q_pop;

  b64lw_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_i),
    .q_full_i (q_full),
    .q_wr_o   (q_wr)
  );

  b64lw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .pop_i  (q_pop),
    .full_o (q_full),
    .head_o (q_head)
  );

  b64lw_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (q_head),
    .pop_o  (q_pop),
    .char_o (char_o)
  );

endmodule

`default_nettype wire

>>> tb/b64lw_encode_check.sv
module b64lw_encode_check (
  input  logic  clk_i,
  input  logic  rst_ni,
  b64lw_in_if   byte_i,
  b64lw_out_if  char_o,
  output int    errors_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import b64lw_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       message_end;
  } enc_char_t;

  // Symbol for value v sits at bits [8*(63-v) +: 8]
  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [15:0] held_q;
  logic [1:0]  phase_q;
  logic [6:0]  column_q;
  enc_char_t   expected_chars[$];

  function automatic logic [7:0] sym_of(input logic [5:0] v);
    return Alphabet[8*(63-v) +: 8];
  endfunction

  // Queue one predicted character at the tail
  function automatic void append_expected(input enc_char_t e);
    expected_chars.insert(expected_chars.size(), e);
  endfunction

  // Append one line character, then a newline when the line fills
  function automatic void put_char(input logic [7:0] c);
    append_expected(enc_char_t'{c, 1'b0, 1'b0});
    column_q = column_q + 7'd1;
    if (column_q >= LineWidth) begin
      append_expected(enc_char_t'{NewlineChar, 1'b0, 1'b0});
      column_q = '0;
    end
  endfunction

  // Predict the characters caused by one accepted byte request
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [23:0] grp;
    int          first;
    enc_char_t   tail;
    first = expected_chars.size();
    if (phase_q >= 2'd2) begin
      grp = {held_q, b};
      put_char(sym_of(grp[23:18]));
      put_char(sym_of(grp[17:12]));
      put_char(sym_of(grp[11:6]));
      put_char(sym_of(grp[5:0]));
      held_q  = '0;
      phase_q = '0;
    end else if (!fin) begin
      // Hold the byte until its group completes
      if (phase_q == 2'd0) begin
        held_q = {b, 8'h00};
      end else begin
        held_q[7:0] = b;
      end
      phase_q = phase_q + 2'd1;
      return;
    end else if (phase_q == 2'd0) begin
      grp = {b, 16'h0000};
      put_char(sym_of(grp[23:18]));
      put_char(sym_of(grp[17:12]));
      put_char(PadChar);
      put_char(PadChar);
    end else begin
      grp = {held_q[15:8], b, 8'h00};
      put_char(sym_of(grp[23:18]));
      put_char(sym_of(grp[17:12]));
      put_char(sym_of(grp[11:6]));
      put_char(PadChar);
    end
    // Close the message: finish an open line, clear the state
    if (fin) begin
      if (column_q != 7'd0) begin
        append_expected(enc_char_t'{NewlineChar, 1'b0, 1'b0});
      end
      held_q   = '0;
      phase_q  = '0;
      column_q = '0;
    end
    if (expected_chars.size() > first) begin
      tail = expected_chars[expected_chars.size()-1];
      tail.run_last    = 1'b1;
      tail.message_end = fin;
      expected_chars[expected_chars.size()-1] = tail;
    end
  endfunction

  // Predict on each byte request, compare each character request
  always @(posedge clk_i or negedge rst_ni) begin
    enc_char_t want;
    if (!rst_ni) begin
      held_q   = '0;
      phase_q  = '0;
      column_q = '0;
      expected_chars.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (byte_i.valid && byte_i.ready) begin
        encode_byte(byte_i.data_byte, byte_i.last);
      end
      if (char_o.valid && char_o.ready) begin
        if (expected_chars.size() == 0) begin
          $error("out_char: expected no character, got %h", char_o.out_char);
          errors_o++;
        end else begin
          want = expected_chars.pop_front();
          if (char_o.out_char !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, char_o.out_char);
            errors_o++;
          end
          if (char_o.run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, char_o.run_last);
            errors_o++;
          end
          if (char_o.message_end !== want.message_end) begin
            $error("message_end: expected %b, got %b", want.message_end,
                   char_o.message_end);
            errors_o++;
          end
        end
      end
      pending_o = expected_chars.size();
    end
  end

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ByteTarget = 180;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 20;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   idle_cycles;

  b64lw_in_if  byte_if ();
  b64lw_out_if char_if ();

  base64_encoder_line_wrap DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .byte_i (byte_if),
    .char_o (char_if)
  );

  b64lw_encode_check u_encode_check (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .byte_i    (byte_if),
    .char_o    (char_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(10, 40);
    end
  endfunction

  // Send one message; hold each request until it is taken
  task automatic send_msg(input logic [7:0] msg[$], input bit burst);
    int gap;
    for (int i = 0; i < msg.size(); i++) begin
      gap = burst ? 0 : pick_gap();
      if (gap > 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      byte_if.valid     <= 1'b1;
      byte_if.data_byte <= msg[i];
      byte_if.last      <= (i == msg.size() - 1);
      do begin
        @(posedge clk);
      end while (!byte_if.ready);
      @(negedge clk);
    end
  endtask

  // Output side: random stalls with occasional long always-ready stretches
  initial begin
    int stall;
    char_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        char_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      char_if.ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(60, 200)) @(negedge clk);
      end else begin
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // Abort when no request moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((byte_if.valid && byte_if.ready) || (char_if.valid && char_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $error("no request accepted for %0d cycles", StallLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] msg[$];
    int         sent;
    int         len;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = 8'h00;
    byte_if.last      = 1'b0;
    rst_n             = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Single byte (two pads), two bytes (one pad), full groups at the extremes and a plain one
    msg = {8'h00};
    send_msg(msg, 1'b0);
    msg = {8'hFF, 8'hFF};
    send_msg(msg, 1'b0);
    msg = {8'h00, 8'h00, 8'h00};
    send_msg(msg, 1'b1);
    msg = {8'hFB, 8'hFF, 8'hBF};
    send_msg(msg, 1'b0);
    msg = {8'h4D, 8'h61, 8'h6E};
    send_msg(msg, 1'b1);
    // Full group followed by short tails of one and two bytes
    msg = {8'h80, 8'h01, 8'h7F, 8'hFE};
    send_msg(msg, 1'b0);
    msg = {8'h55, 8'hAA, 8'h0F, 8'hF0, 8'hC3};
    send_msg(msg, 1'b0);

    // Random messages: mostly short, some around one full line
    sent = 0;
    while (sent < ByteTarget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(1, 6);
        4, 5, 6, 7: len = $urandom_range(7, 30);
        default:    len = $urandom_range(45, 50);
      endcase
      msg.delete();
      for (int i = 0; i < len; i++) begin
        msg.insert(msg.size(), 8'($urandom_range(0, 255)));
      end
      send_msg(msg, $urandom_range(0, 4) == 0);
      sent += len;
    end
    byte_if.valid <= 1'b0;

    // Drain the outstanding characters, then watch for extras
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DrainCycles) @(negedge clk);

    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
